// ----- rtl/core/aabb_table_pair_finder_unit_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef AABB_TABLE_PAIR_FINDER_UNIT_MACROS_SVH
`define AABB_TABLE_PAIR_FINDER_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ATPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked at the next rising clock edge.
`define ATPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/atpf_pkg.sv -----
// ----------------------------------------------------------------------------
// atpf_pkg
// Types and constants shared by the box table pair finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package atpf_pkg;
    localparam int CAPACITY  = 64;
    localparam int MAX_PAIRS = 63;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_PAIRS  = 2'd2;
    localparam logic [1:0] FUNC_QUERY  = 2'd3;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_QUERY  = 3'd2;
    localparam logic [2:0] KIND_PAIR   = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;

    typedef struct packed {
        logic        [1:0]  func;
        logic        [15:0] body_id;
        logic        [15:0] other_id;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic        ok;
        logic [15:0] pair_a;
        logic [15:0] pair_b;
        logic [5:0]  pair_count;
        logic        last;
    } t_rsp;

    // One table entry as stored in memory.
    typedef struct packed {
        logic        [15:0] id;
        logic signed [31:0] lo_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] lo_z;
        logic signed [31:0] hi_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] hi_z;
    } t_entry;

    // Inclusive overlap test on signed corners.
    function automatic logic boxes_touch(input t_entry a, input t_entry b);
        logic t;
        t = !(a.hi_x < b.lo_x || a.lo_x > b.hi_x) &&
            !(a.hi_y < b.lo_y || a.lo_y > b.hi_y) &&
            !(a.hi_z < b.lo_z || a.lo_z > b.hi_z);
        return t;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/atpf_table_ram.sv -----
// ----------------------------------------------------------------------------
// atpf_table_ram
// Entry memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module atpf_table_ram (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire [atpf_pkg::IDX_W-1:0]  i_waddr,
    input  wire atpf_pkg::t_entry      i_wdata,
    input  wire [atpf_pkg::IDX_W-1:0]  i_raddr_a,
    input  wire [atpf_pkg::IDX_W-1:0]  i_raddr_b,
    output atpf_pkg::t_entry           o_rdata_a,
    output atpf_pkg::t_entry           o_rdata_b
);
    import atpf_pkg::*;

    t_entry r_mem [CAPACITY];

    // Write port and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

// ----- rtl/core/aabb_table_pair_finder_unit.sv -----
// ----------------------------------------------------------------------------
// aabb_table_pair_finder_unit
// Brute-force broadphase over a table of axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//   A request on i_req (valid/stall) carries an operation: insert, remove,
//   find overlapping pairs (up to MAX_PAIRS), or query two ids. Results
//   leave on o_rsp (valid/stall); the last result of each request has last
//   set. Insert is answered in the cycle after it is accepted, and the next
//   request can follow at once. Remove and query read one entry per cycle;
//   remove then copies the last entry into the freed slot. Find-pairs reads
//   one pair (i, j) per cycle through the two read ports of the entry
//   memory while the output is not stalled.
//   One request is worked on at a time; the next is taken once the last
//   result has moved into the output register and is not held by a stall.
//   A stall on the output freezes the pair scan until the pending result
//   is taken. Reset empties the table at once (the entry count goes to
//   zero); the memory itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aabb_table_pair_finder_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    output logic                o_req_stall,
    input  wire atpf_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire                 i_rsp_stall,
    output atpf_pkg::t_rsp      o_rsp
);
    import atpf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_MOVE  = 3'd2;
    localparam logic [2:0] ST_PAIRS = 3'd3;
    localparam logic [2:0] ST_QEVAL = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_req             r_req, n_req;
    logic [CNT_W-1:0] r_i, n_i;       // issue index (scan) or outer index
    logic [CNT_W-1:0] r_j, n_j;       // inner index for pairs
    logic             r_pend, n_pend; // read data valid next cycle
    logic [CNT_W-1:0] r_pi, n_pi;     // index belonging to read data
    logic [5:0]       r_npairs, n_npairs;
    logic             r_has1, n_has1, r_has2, n_has2;
    logic [IDX_W-1:0] r_qa, n_qa, r_qb, n_qb;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic             r_ovalid, n_ovalid;
    t_rsp             r_orsp, n_orsp;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
    t_entry           wdata, rd_a, rd_b;
    logic             out_free;

    atpf_table_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign out_free    = !r_ovalid || !i_rsp_stall;
    assign o_req_stall = (r_state != ST_IDLE) || !out_free;
    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_orsp;

    // Build one result value.
    function automatic t_rsp mk(input logic [2:0] k, input logic okv,
                                input logic [15:0] a, input logic [15:0] b,
                                input logic [5:0] c, input logic l);
        t_rsp r;
        r.kind = k; r.ok = okv; r.pair_a = a; r.pair_b = b;
        r.pair_count = c; r.last = l;
        return r;
    endfunction

    // Sequencer: reads, compares and writes back the entry memory.
    always_comb begin
        n_state = r_state; n_count = r_count; n_req = r_req;
        n_i = r_i; n_j = r_j; n_pend = 1'b0; n_pi = r_pi;
        n_npairs = r_npairs; n_has1 = r_has1; n_has2 = r_has2;
        n_qa = r_qa; n_qb = r_qb; n_slot = r_slot;
        n_ovalid = r_ovalid && i_rsp_stall; n_orsp = r_orsp;
        we = 1'b0; waddr = r_count[IDX_W-1:0];
        wdata.id = r_req.body_id;
        wdata.lo_x = r_req.min_x; wdata.lo_y = r_req.min_y; wdata.lo_z = r_req.min_z;
        wdata.hi_x = r_req.max_x; wdata.hi_y = r_req.max_y; wdata.hi_z = r_req.max_z;
        raddr_a = r_i[IDX_W-1:0]; raddr_b = r_j[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid && out_free) begin
                    n_req = i_req; n_i = '0; n_j = CNT_W'(1);
                    n_npairs = '0; n_has1 = 1'b0; n_has2 = 1'b0;
                    case (i_req.func)
                        FUNC_INSERT: begin
                            n_ovalid = 1'b1;
                            if (r_count < CNT_W'(CAPACITY)) begin
                                we = 1'b1;
                                wdata.id = i_req.body_id;
                                wdata.lo_x = i_req.min_x; wdata.lo_y = i_req.min_y;
                                wdata.lo_z = i_req.min_z; wdata.hi_x = i_req.max_x;
                                wdata.hi_y = i_req.max_y; wdata.hi_z = i_req.max_z;
                                n_count = r_count + CNT_W'(1);
                                n_orsp = mk(KIND_INSERT, 1'b1, '0, '0, '0, 1'b1);
                            end else begin
                                n_orsp = mk(KIND_INSERT, 1'b0, '0, '0, '0, 1'b1);
                            end
                        end
                        FUNC_PAIRS: n_state = ST_PAIRS;
                        default:    n_state = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                // Check returned entry, then issue the next read.
                if (r_pend) begin
                    if (r_req.func == FUNC_REMOVE) begin
                        if (rd_a.id == r_req.body_id) begin
                            n_slot = r_pi[IDX_W-1:0];
                            n_i = r_count - CNT_W'(1);
                            n_state = ST_MOVE;
                        end
                    end else begin
                        if (rd_a.id == r_req.body_id) begin
                            n_has1 = 1'b1; n_qa = r_pi[IDX_W-1:0];
                        end
                        if (rd_a.id == r_req.other_id) begin
                            n_has2 = 1'b1; n_qb = r_pi[IDX_W-1:0];
                        end
                        if ((r_has1 || rd_a.id == r_req.body_id) &&
                            (r_has2 || rd_a.id == r_req.other_id)) begin
                            n_state = ST_QEVAL;
                        end
                    end
                end
                if (n_state == ST_SCAN) begin
                    if (r_i < r_count) begin
                        raddr_a = r_i[IDX_W-1:0];
                        n_pend = 1'b1; n_pi = r_i; n_i = r_i + CNT_W'(1);
                    end else if (!r_pend && out_free) begin
                        n_state = ST_IDLE; n_ovalid = 1'b1;
                        n_orsp = (r_req.func == FUNC_REMOVE) ?
                                 mk(KIND_REMOVE, 1'b0, '0, '0, '0, 1'b1) :
                                 mk(KIND_QUERY, 1'b0, '0, '0, '0, 1'b1);
                    end
                end else if (n_state == ST_MOVE) begin
                    raddr_a = n_i[IDX_W-1:0];
                    n_pend = 1'b1;
                end else begin
                    raddr_a = n_qa; raddr_b = n_qb;
                    n_pend = 1'b1;
                end
            end
            ST_MOVE: begin
                // Copy last entry into the freed slot.
                if (out_free) begin
                    we = 1'b1; waddr = r_slot; wdata = rd_a;
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_IDLE; n_ovalid = 1'b1;
                    n_orsp = mk(KIND_REMOVE, 1'b1, '0, '0, '0, 1'b1);
                end else begin
                    raddr_a = r_i[IDX_W-1:0];
                end
            end
            ST_QEVAL: begin
                if (out_free) begin
                    n_state = ST_IDLE; n_ovalid = 1'b1;
                    n_orsp = mk(KIND_QUERY, boxes_touch(rd_a, rd_b), '0, '0, '0, 1'b1);
                end else begin
                    raddr_a = r_qa; raddr_b = r_qb;
                end
            end
            ST_PAIRS: begin
                // r_pend: rd_a/rd_b hold the pair (r_qa, r_qb) issued last cycle.
                if (r_pend && !out_free) begin
                    // Hold the read addresses until the result slot frees.
                    raddr_a = r_qa; raddr_b = r_qb;
                    n_pend = 1'b1;
                end else begin
                    if (r_pend && boxes_touch(rd_a, rd_b)) begin
                        n_ovalid = 1'b1;
                        n_orsp = mk(KIND_PAIR, 1'b0, rd_a.id, rd_b.id, '0, 1'b0);
                        n_npairs = r_npairs + 6'd1;
                    end
                    if (n_npairs < 6'(MAX_PAIRS) && r_j < r_count) begin
                        raddr_a = r_i[IDX_W-1:0]; raddr_b = r_j[IDX_W-1:0];
                        n_qa = r_i[IDX_W-1:0]; n_qb = r_j[IDX_W-1:0];
                        n_pend = 1'b1;
                        if (r_j + CNT_W'(1) < r_count) begin
                            n_j = r_j + CNT_W'(1);
                        end else begin
                            n_i = r_i + CNT_W'(1);
                            n_j = r_i + CNT_W'(2);
                        end
                    end else if (!r_pend && out_free) begin
                        n_state = ST_IDLE; n_ovalid = 1'b1;
                        n_orsp = mk(KIND_DONE, 1'b0, '0, '0, r_npairs, 1'b1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_count <= '0; r_pend <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_pend <= n_pend;
            r_ovalid <= n_ovalid;
        end
        r_req <= n_req; r_i <= n_i; r_j <= n_j; r_pi <= n_pi;
        r_npairs <= n_npairs; r_has1 <= n_has1; r_has2 <= n_has2;
        r_qa <= n_qa; r_qb <= n_qb; r_slot <= n_slot; r_orsp <= n_orsp;
    end
endmodule
`default_nettype wire

// ----- rtl/core/atpf_checker.sv -----
// ----------------------------------------------------------------------------
// atpf_checker
// Port-level checks of the box table pair finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "aabb_table_pair_finder_unit_macros.svh"
module atpf_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_req_valid,
    input wire                 o_req_stall,
    input wire atpf_pkg::t_req i_req,
    input wire                 o_rsp_valid,
    input wire                 i_rsp_stall,
    input wire atpf_pkg::t_rsp o_rsp
);
    import atpf_pkg::*;

    // A stalled result holds.
    `ATPF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp), "stalled result changed")
    // Only pair results are not final.
    `ATPF_ASSERT_IMP(a_last, i_clk, i_rst_n, o_rsp_valid, o_rsp.last == (o_rsp.kind != KIND_PAIR), "last flag wrong")
    // Pair and done results never carry ok.
    `ATPF_ASSERT_IMP(a_ok, i_clk, i_rst_n, o_rsp_valid && (o_rsp.kind == KIND_PAIR || o_rsp.kind == KIND_DONE), !o_rsp.ok, "ok set on pair")
    // An insert request is answered next cycle.
    `ATPF_ASSERT_NEXT(a_ins, i_clk, i_rst_n, i_req_valid && !o_req_stall && i_req.func == FUNC_INSERT, o_rsp_valid && o_rsp.kind == KIND_INSERT, "insert not answered")
endmodule

bind aabb_table_pair_finder_unit atpf_checker u_atpf_checker (.*);
`default_nettype wire
